// ----- rtl/core/lpse_pkg.sv -----
`default_nettype none
package lpse_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS  = 2'd0,
    REG_LEVEL_LIMIT = 2'd1,
    REG_GRB_ORDER   = 2'd2
  } cfg_reg_e;

  localparam logic [3:0] NIB_ONE  = 4'h3;
  localparam logic [3:0] NIB_ZERO = 4'h1;

  typedef struct packed {
    logic [CHAN_W-1:0] brightness;
    logic [CHAN_W-1:0] level_limit;
    logic              grb_order;
  } cfg_t;

  typedef logic [WORD_W-1:0] word_t;

  // floor(p / 255) for p <= 255 * 255
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
    logic [2*CHAN_W:0] t;
    t = {1'b0, p} + {9'd0, p[2*CHAN_W-1:CHAN_W]} + 17'd1;
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

  // bit 7 goes to the lowest nibble
  function automatic word_t encode_byte(input logic [CHAN_W-1:0] v);
    word_t w;
    w = '0;
    for (int i = 0; i < CHAN_W; i++) begin
      w[4*i +: 4] = v[CHAN_W-1-i] ? NIB_ONE : NIB_ZERO;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/lpse_if.sv -----
`default_nettype none
interface lpse_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;
  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface lpse_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] spi_word;
  logic        last;
  modport source (output valid, spi_word, last, input ready);
  modport sink (input valid, spi_word, last, output ready);
endinterface

interface lpse_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/lpse_scale.sv -----
`default_nettype none
module lpse_scale (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [lpse_pkg::CHAN_W-1:0] brightness,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [lpse_pkg::CHAN_W-1:0] in_red,
  input  wire logic [lpse_pkg::CHAN_W-1:0] in_green,
  input  wire logic [lpse_pkg::CHAN_W-1:0] in_blue,
  input  wire logic                      in_fs,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [lpse_pkg::CHAN_W-1:0]    out_red,
  output logic [lpse_pkg::CHAN_W-1:0]    out_green,
  output logic [lpse_pkg::CHAN_W-1:0]    out_blue,
  output logic                           out_fs
);
  import lpse_pkg::*;

  logic                a_valid;
  logic [2*CHAN_W-1:0] a_red;
  logic [2*CHAN_W-1:0] a_green;
  logic [2*CHAN_W-1:0] a_blue;
  logic                a_fs;
  logic                a_ready;
  logic                b_ready;

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_red   <= in_red * brightness;
      a_green <= in_green * brightness;
      a_blue  <= in_blue * brightness;
      a_fs    <= in_fs;
    end
  end

  // divide by 255
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_ready) begin
      out_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      out_red   <= div255(a_red);
      out_green <= div255(a_green);
      out_blue  <= div255(a_blue);
      out_fs    <= a_fs;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lpse_encode.sv -----
`default_nettype none
module lpse_encode (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lpse_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lpse_pkg::CHAN_W-1:0] in_red,
  input  wire logic [lpse_pkg::CHAN_W-1:0] in_green,
  input  wire logic [lpse_pkg::CHAN_W-1:0] in_blue,
  input  wire logic                        in_fs,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output lpse_pkg::word_t                  out_words [3],
  output logic                             out_fs
);
  import lpse_pkg::*;

  logic [CHAN_W-1:0] red_c;
  logic [CHAN_W-1:0] green_c;
  logic [CHAN_W-1:0] blue_c;
  logic [CHAN_W-1:0] first_c;
  logic [CHAN_W-1:0] second_c;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    red_c    = (in_red > cfg.level_limit) ? cfg.level_limit : in_red;
    green_c  = (in_green > cfg.level_limit) ? cfg.level_limit : in_green;
    blue_c   = (in_blue > cfg.level_limit) ? cfg.level_limit : in_blue;
    first_c  = cfg.grb_order ? green_c : red_c;
    second_c = cfg.grb_order ? red_c : green_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_words[0] <= encode_byte(first_c);
      out_words[1] <= encode_byte(second_c);
      out_words[2] <= encode_byte(blue_c);
      out_fs       <= in_fs;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lpse_emit.sv -----
`default_nettype none
module lpse_emit #(
  parameter int unsigned RESET_WORDS = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire lpse_pkg::word_t in_words [3],
  input  wire logic            in_fs,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lpse_pkg::word_t      out_word,
  output logic                 out_last
);
  import lpse_pkg::*;

  localparam int unsigned IDX_W = $clog2(RESET_WORDS + 3);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(RESET_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RESET_WORDS + 2);

  logic             busy;
  logic [IDX_W-1:0] idx;
  word_t            words [3];
  logic             adv;
  logic             at_last;
  logic [1:0]       sel;
  word_t            word_next;

  assign adv      = !out_valid || out_ready;
  assign at_last  = idx == IDX_LAST;
  assign in_ready = !busy || (adv && at_last);
  assign sel      = 2'(idx - IDX_FIRST);
  assign word_next = (idx < IDX_FIRST) ? '0 : words[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_FIRST;
    end else if (in_ready && in_valid) begin
      busy <= 1'b1;
      idx  <= in_fs ? '0 : IDX_FIRST;
    end else if (busy && adv) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      words <= in_words;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= busy;
    end
    if (adv && busy) begin
      out_word <= word_next;
      out_last <= at_last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/led_pixel_spi_pulse_encoder_unit.sv -----
// LED pixel to SPI pulse encoder.
// pixel (sink): one transfer per pixel, red/green/blue bytes and frame_start.
// word (source): one 32-bit SPI word per transfer, sent lsb first, one
//   nibble per data bit; last marks the third word of each pixel.
// cfg (sink): register writes, always ready; index 0 brightness,
//   1 level_limit, 2 grb_order; other indexes are ignored. Write only
//   while no pixel is in flight.
// Path: multiply stage, divide-by-255 stage, clamp/order/encode stage,
//   word sequencer, output register.
// Output: three words per pixel, RESET_WORDS zero words first when frame_start is set;
//   one word per cycle while word.ready is high and pixels keep coming; the next pixel is taken with the last word.
// Reset: all stages empty, brightness 255, level_limit 255, RGB order.
// A stall on word holds the output word; the stages behind it fill and
//   pixel.ready drops, nothing is lost or repeated.
`default_nettype none
module led_pixel_spi_pulse_encoder_unit #(
  parameter int unsigned RESET_WORDS = 25
) (
  input wire logic    clk,
  input wire logic    rst,
  lpse_pixel_if.sink  pixel,
  lpse_word_if.source word,
  lpse_cfg_if.sink    cfg
);
  import lpse_pkg::*;

  cfg_t              regs;
  logic              sc_valid;
  logic              sc_ready;
  logic [CHAN_W-1:0] sc_red;
  logic [CHAN_W-1:0] sc_green;
  logic [CHAN_W-1:0] sc_blue;
  logic              sc_fs;
  logic              en_valid;
  logic              en_ready;
  word_t             en_words [3];
  logic              en_fs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.brightness  <= 8'd255;
      regs.level_limit <= 8'd255;
      regs.grb_order   <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_BRIGHTNESS) begin
        regs.brightness <= cfg.data;
      end else if (cfg.index == REG_LEVEL_LIMIT) begin
        regs.level_limit <= cfg.data;
      end else if (cfg.index == REG_GRB_ORDER) begin
        regs.grb_order <= cfg.data[0];
      end
    end
  end

  lpse_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .brightness (regs.brightness),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .in_red     (pixel.red),
    .in_green   (pixel.green),
    .in_blue    (pixel.blue),
    .in_fs      (pixel.frame_start),
    .out_valid  (sc_valid),
    .out_ready  (sc_ready),
    .out_red    (sc_red),
    .out_green  (sc_green),
    .out_blue   (sc_blue),
    .out_fs     (sc_fs)
  );

  lpse_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .in_valid  (sc_valid),
    .in_ready  (sc_ready),
    .in_red    (sc_red),
    .in_green  (sc_green),
    .in_blue   (sc_blue),
    .in_fs     (sc_fs),
    .out_valid (en_valid),
    .out_ready (en_ready),
    .out_words (en_words),
    .out_fs    (en_fs)
  );

  lpse_emit #(
    .RESET_WORDS (RESET_WORDS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (en_valid),
    .in_ready  (en_ready),
    .in_words  (en_words),
    .in_fs     (en_fs),
    .out_valid (word.valid),
    .out_ready (word.ready),
    .out_word  (word.spi_word),
    .out_last  (word.last)
  );

endmodule
`default_nettype wire

// ----- rtl/core/lpse_checker.sv -----
`default_nettype none
module lpse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        word_valid,
  input wire logic        word_ready,
  input wire logic [31:0] spi_word,
  input wire logic        last
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid && $stable(spi_word) && $stable(last))
    else $error("stalled output word changed");

  // every word is a reset zero word or eight well-formed pulse nibbles
  a_form: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> spi_word == 32'h0 ||
      ((spi_word & 32'hCCCCCCCC) == 32'h0 && (spi_word & 32'h11111111) == 32'h11111111))
    else $error("malformed SPI word");

  a_zero_not_last: assert property (@(posedge clk) disable iff (rst)
    word_valid && spi_word == 32'h0 |-> !last)
    else $error("reset word flagged as last");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !word_valid)
    else $error("output valid straight after reset");

endmodule

bind led_pixel_spi_pulse_encoder_unit lpse_checker u_lpse_checker (
  .clk        (clk),
  .rst        (rst),
  .word_valid (word.valid),
  .word_ready (word.ready),
  .spi_word   (word.spi_word),
  .last       (word.last)
);
`default_nettype wire

// ----- test/led_pixel_spi_pulse_encoder_unit_test.sv -----
`timescale 1ns / 1ps
module led_pixel_spi_pulse_encoder_unit_test;
  import lpse_pkg::*;

  localparam int unsigned RESET_WORDS = 25;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_start;
  } pixel_t;

  typedef struct packed {
    word_t spi_word;
    logic  last;
  } spi_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpse_pixel_if pixel_if();
  lpse_word_if  word_if();
  lpse_cfg_if   cfg_if();

  led_pixel_spi_pulse_encoder_unit #(
    .RESET_WORDS(RESET_WORDS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .pixel(pixel_if),
    .word (word_if),
    .cfg  (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_t      pending_pixels[$];
  spi_result_t expected_words[$];

  logic [CHAN_W-1:0] bright_reg;
  logic [CHAN_W-1:0] limit_reg;
  logic              grb_reg;

  int  errors          = 0;
  int  pixels_queued   = 0;
  int  pixels_accepted = 0;
  bit  idle_on         = 1'b1;
  bit  hold_request    = 1'b0;
  bit  hold_fired      = 1'b0;
  int  hold_left       = 0;
  int  stall_left      = 0;
  int  send_gap        = 0;
  bit  offer;
  bit  take;
  int  quiet_cycles    = 0;
  pixel_t      cur_pixel;
  spi_result_t head;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [CHAN_W-1:0] scaled_level(input logic [CHAN_W-1:0] c);
    int unsigned v;
    v = (int'(c) * int'(bright_reg)) / 255;
    if (v > limit_reg) begin
      v = 32'(limit_reg);
    end
    return v[CHAN_W-1:0];
  endfunction

  function automatic word_t nibble_word(input logic [CHAN_W-1:0] v);
    word_t w;
    w = '0;
    for (int i = 0; i < CHAN_W; i++) begin
      w[4*i +: 4] = v[CHAN_W-1-i] ? NIB_ONE : NIB_ZERO;
    end
    return w;
  endfunction

  task automatic predict_pixel_words(input pixel_t p);
    logic [CHAN_W-1:0] order[3];
    spi_result_t r;
    if (p.frame_start) begin
      repeat (RESET_WORDS) expected_words.push_back('{spi_word: '0, last: 1'b0});
    end
    order[0] = grb_reg ? scaled_level(p.green) : scaled_level(p.red);
    order[1] = grb_reg ? scaled_level(p.red) : scaled_level(p.green);
    order[2] = scaled_level(p.blue);
    for (int k = 0; k < 3; k++) begin
      r.spi_word = nibble_word(order[k]);
      r.last = (k == 2);
      expected_words.push_back(r);
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pixel_if.valid <= 1'b0;
    end else begin
      offer = pixel_if.valid;
      if (pixel_if.valid && pixel_if.ready) begin
        predict_pixel_words(cur_pixel);
        pixels_accepted++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pixels.size() > 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 12) - 1;
          end else begin
            cur_pixel = pending_pixels.pop_front();
            offer = 1'b1;
          end
        end
      end
      pixel_if.valid <= offer;
      pixel_if.red <= cur_pixel.red;
      pixel_if.green <= cur_pixel.green;
      pixel_if.blue <= cur_pixel.blue;
      pixel_if.frame_start <= cur_pixel.frame_start;
    end
  end

  // word monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      word_if.ready <= 1'b0;
    end else begin
      if (word_if.valid && word_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", word_if.spi_word,
                                    word_if.last));
        end else begin
          head = expected_words.pop_front();
          if (word_if.spi_word !== head.spi_word) begin
            report_mismatch($sformatf("spi_word %h, expected %h", word_if.spi_word,
                                      head.spi_word));
          end
          if (word_if.last !== head.last) begin
            report_mismatch($sformatf("last %b, expected %b on word %h", word_if.last,
                                      head.last, head.spi_word));
          end
        end
      end
      if (hold_request && !hold_fired) begin
        hold_left = 300;
        hold_fired = 1'b1;
      end
      take = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        take = 1'b1;
      end
      word_if.ready <= take;
    end
  end

  // register shadow
  always @(posedge clk) begin
    if (rst) begin
      bright_reg = 8'd255;
      limit_reg = 8'd255;
      grb_reg = 1'b0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_BRIGHTNESS:  bright_reg = cfg_if.data;
        REG_LEVEL_LIMIT: limit_reg = cfg_if.data;
        REG_GRB_ORDER:   grb_reg = cfg_if.data[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_if.valid && pixel_if.ready) || (word_if.valid && word_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] b, input logic [7:0] l, input logic g);
    write_reg(REG_BRIGHTNESS, b);
    write_reg(REG_LEVEL_LIMIT, l);
    write_reg(REG_GRB_ORDER, {7'($urandom), g});
  endtask

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic fs);
    pending_pixels.push_back('{red: r, green: g, blue: b, frame_start: fs});
    pixels_queued++;
  endtask

  task automatic wait_drained();
    while (pixels_accepted != pixels_queued || expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    pixel_if.valid = 1'b0;
    pixel_if.red = '0;
    pixel_if.green = '0;
    pixel_if.blue = '0;
    pixel_if.frame_start = 1'b0;
    word_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    cur_pixel = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values: full scale, no clamp, RGB
    queue_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_pixel(8'hAA, 8'h55, 8'h0F, 1'b0);
    queue_pixel(8'h80, 8'h01, 8'hFE, 1'b1);
    wait_drained();

    write_reg(REG_BRIGHTNESS, 8'd0);
    queue_pixel(8'hFF, 8'h80, 8'h01, 1'b0);
    wait_drained();

    set_config(8'd128, 8'd100, 1'b0);
    queue_pixel(8'hFF, 8'hC8, 8'hFE, 1'b0);
    queue_pixel(8'h01, 8'h02, 8'h03, 1'b0);
    queue_pixel(8'h64, 8'hC9, 8'hCA, 1'b1);
    wait_drained();

    write_reg(REG_GRB_ORDER, 8'hFF);
    queue_pixel(8'h12, 8'hF0, 8'h0F, 1'b0);
    queue_pixel(8'hFF, 8'h00, 8'h80, 1'b0);
    wait_drained();

    write_reg(REG_LEVEL_LIMIT, 8'd0);
    queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    wait_drained();

    // unmapped index is dropped; order bit taken from bit 0 only
    write_reg(REG_UNUSED, 8'h00);
    write_reg(REG_GRB_ORDER, 8'hFE);
    write_reg(REG_BRIGHTNESS, 8'd1);
    write_reg(REG_LEVEL_LIMIT, 8'd255);
    queue_pixel(8'hFF, 8'hFE, 8'h00, 1'b0);
    wait_drained();

    set_config(8'd255, 8'd255, 1'b1);
    queue_pixel(8'hC3, 8'h3C, 8'h81, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 0) begin
        set_config(8'd255, 8'd255, 1'($urandom));
      end else begin
        set_config(pick_level(), pick_level(), 1'($urandom));
      end
      idle_on = (phase < 4);
      hold_request = (phase == 1);
      repeat (22) begin
        queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 5) == 0);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
